@@ hw/rtl/stcs_pkg.sv @@
`timescale 1ns / 1ps
// ============================================================================
// stcs_pkg
// Shared constants, types and helpers of the sparse ternary challenge sampler.
// ============================================================================
package stcs_pkg;

    // number of coefficient positions in the challenge polynomial
    localparam int NUM_COEFFS = 512;
    localparam int POS_W      = (NUM_COEFFS > 1) ? $clog2(NUM_COEFFS) : 1;

    // fixed field widths
    localparam int WORD_W     = 16;
    localparam int POSITION_W = 9;
    localparam int WEIGHT_W   = 10;

    // occupancy map stores an epoch mark per position
    localparam int EPOCH_W = 6;
    localparam logic [EPOCH_W-1:0] EPOCH_FIRST = EPOCH_W'(1);
    localparam logic [EPOCH_W-1:0] EPOCH_MAX   = {EPOCH_W{1'b1}};
    localparam logic [EPOCH_W-1:0] EPOCH_NONE  = {EPOCH_W{1'b0}};

    // last index of the map, end of the clearing pass
    localparam logic [POS_W-1:0] LAST_IDX = POS_W'(NUM_COEFFS - 1);

    // input kinds
    localparam logic OP_BEGIN = 1'b0;
    localparam logic OP_WORD  = 1'b1;

    // one classified item in the queue
    typedef struct packed {
        logic                  is_word;
        logic [POS_W-1:0]      idx;
        logic [POSITION_W-1:0] position;
        logic                  positive;
    } item_t;

    // head of the queue as seen by the back part
    typedef struct packed {
        logic  valid;
        item_t item;
    } queue_head_t;

    // position of a word: bits above the sign, masked to the map size
    function automatic logic [WORD_W-1:0] masked_pos(input logic [WORD_W-1:0] word);
        logic [WORD_W-1:0] mask;
        mask = WORD_W'(NUM_COEFFS - 1);
        return (word >> 1) & mask;
    endfunction

endpackage

@@ hw/rtl/stcs_ram.sv @@
`timescale 1ns / 1ps
// ============================================================================
// stcs_ram
// Generic single-write, single-read RAM with registered read data.
// ============================================================================
module stcs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                     clk,
    input  logic                                     wr_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  logic [WIDTH-1:0]                         wr_data,
    input  logic                                     rd_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output logic [WIDTH-1:0]                         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // registered read port
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

@@ hw/rtl/stcs_front.sv @@
`timescale 1ns / 1ps
// ============================================================================
// stcs_front
// Accepts input beats, splits each word into position and sign, and holds
// the classified items in a two-entry queue for the back part.
// ============================================================================
module stcs_front
    import stcs_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              s_axis_tvalid,
    output logic              s_axis_tready,
    input  logic [WORD_W-1:0] s_axis_tdata,   // [15:0] word
    input  logic              s_axis_tuser,   // [0] op
    input  logic              busy,
    output queue_head_t       head,
    input  logic              pop
);

    item_t       entry_reg [2];
    logic        wr_ptr_reg;
    logic        wr_ptr_next;
    logic        rd_ptr_reg;
    logic        rd_ptr_next;
    logic [1:0]  count_reg;
    logic [1:0]  count_next;
    logic        push;
    logic        do_pop;
    item_t       new_item;
    logic [WORD_W-1:0] pos_full;

    // classify the incoming beat
    always_comb
    begin
        pos_full          = masked_pos(s_axis_tdata);
        new_item.is_word  = (s_axis_tuser == OP_WORD);
        new_item.idx      = pos_full[POS_W-1:0];
        new_item.position = pos_full[POSITION_W-1:0];
        new_item.positive = s_axis_tdata[0];
    end

    // handshake
    assign s_axis_tready = (count_reg != 2'd2) && !busy;
    assign push          = s_axis_tvalid && s_axis_tready;
    assign do_pop        = pop && (count_reg != 2'd0);

    // queue pointers and fill count
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg ^ push;
        rd_ptr_next = rd_ptr_reg ^ do_pop;
        count_next  = count_reg + 2'(push) - 2'(do_pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // queue storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= new_item;
        end
    end

    // head of queue
    assign head.valid = (count_reg != 2'd0);
    assign head.item  = entry_reg[rd_ptr_reg];

endmodule

@@ hw/rtl/stcs_back.sv @@
`timescale 1ns / 1ps
// ============================================================================
// stcs_back
// Carries out queued items on the occupancy map: read-and-set of one position
// per cycle unless clearing or stalled, accepted count and output register.
// ============================================================================
module stcs_back
    import stcs_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic [WEIGHT_W-1:0]   weight,
    input  queue_head_t           head,
    output logic                  pop,
    output logic                  busy,
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    output logic [15:0]           m_axis_tdata,   // [8:0] position, [9] positive
    output logic                  m_axis_tlast    // last
);

    // map read stage
    logic                 b_valid_reg;
    item_t                b_item_reg;
    logic                 fwd_valid_reg;
    logic [POS_W-1:0]     fwd_idx_reg;

    // map control
    logic [EPOCH_W-1:0]   epoch_reg;
    logic                 clearing_reg;
    logic [POS_W-1:0]     clr_idx_reg;
    logic [WEIGHT_W-1:0]  count_reg;

    // output register
    logic                  out_valid_reg;
    logic [POSITION_W-1:0] out_position_reg;
    logic                  out_positive_reg;
    logic                  out_last_reg;

    logic                 occupied;
    logic                 complete;
    logic                 take;
    logic                 out_free;
    logic                 advance;
    logic                 wrap;
    logic                 ram_wr_en;
    logic [POS_W-1:0]     ram_wr_addr;
    logic [EPOCH_W-1:0]   ram_wr_data;
    logic [EPOCH_W-1:0]   ram_rd_data;
    logic [WEIGHT_W-1:0]  count_inc;

    // occupancy map, one epoch mark per position
    stcs_ram #(
        .WIDTH (EPOCH_W),
        .DEPTH (NUM_COEFFS)
    ) u_map (
        .clk     (clk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data),
        .rd_en   (pop),
        .rd_addr (head.item.idx),
        .rd_data (ram_rd_data)
    );

    // decision for the item in the read stage
    always_comb
    begin
        count_inc = count_reg + WEIGHT_W'(1);
        occupied  = (ram_rd_data == epoch_reg)
                 || (fwd_valid_reg && (fwd_idx_reg == b_item_reg.idx));
        complete  = (count_reg >= weight);
        take      = b_item_reg.is_word && !complete && !occupied;
        out_free  = !out_valid_reg || m_axis_tready;
        advance   = b_valid_reg && out_free && !clearing_reg;
        wrap      = advance && !b_item_reg.is_word && (epoch_reg == EPOCH_MAX);
        pop       = head.valid && (!b_valid_reg || advance) && !clearing_reg && !wrap;
    end

    // map write: clearing pass or mark of a newly set position
    always_comb
    begin
        if (clearing_reg)
        begin
            ram_wr_en   = 1'b1;
            ram_wr_addr = clr_idx_reg;
            ram_wr_data = EPOCH_NONE;
        end
        else
        begin
            ram_wr_en   = advance && take;
            ram_wr_addr = b_item_reg.idx;
            ram_wr_data = epoch_reg;
        end
    end

    assign busy = clearing_reg;

    // read stage and forwarding of the write made while its read was issued
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b_valid_reg   <= 1'b0;
            fwd_valid_reg <= 1'b0;
        end
        else if (pop)
        begin
            b_valid_reg   <= 1'b1;
            fwd_valid_reg <= advance && take;
        end
        else if (advance)
        begin
            b_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            b_item_reg  <= head.item;
            fwd_idx_reg <= b_item_reg.idx;
        end
    end

    // epoch, clearing pass and accepted count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            epoch_reg    <= EPOCH_FIRST;
            clearing_reg <= 1'b1;
            clr_idx_reg  <= '0;
            count_reg    <= '0;
        end
        else
        begin
            if (clearing_reg)
            begin
                clr_idx_reg <= clr_idx_reg + POS_W'(1);
                if (clr_idx_reg == LAST_IDX)
                begin
                    clearing_reg <= 1'b0;
                    epoch_reg    <= EPOCH_FIRST;
                end
            end
            else if (wrap)
            begin
                clearing_reg <= 1'b1;
                clr_idx_reg  <= '0;
                count_reg    <= '0;
            end
            else if (advance && !b_item_reg.is_word)
            begin
                epoch_reg <= epoch_reg + EPOCH_W'(1);
                count_reg <= '0;
            end
            else if (advance && take)
            begin
                count_reg <= count_inc;
            end
        end
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance && take)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_axis_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && take)
        begin
            out_position_reg <= b_item_reg.position;
            out_positive_reg <= b_item_reg.positive;
            out_last_reg     <= (count_inc == weight);
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {6'b0, out_positive_reg, out_position_reg};
    assign m_axis_tlast  = out_last_reg;

    // no map read while the clearing pass owns the write port
    a_no_pop_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
        clearing_reg |-> !pop)
        else $error("queue popped during clearing pass");

    // every accepted position raises the count by one
    a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && take && !clearing_reg) |=> (count_reg == $past(count_inc)))
        else $error("accepted count did not step");

    // normal writes mark the current epoch
    a_write_epoch: assert property (@(posedge clk) disable iff (!rst_n)
        (ram_wr_en && !clearing_reg) |-> (ram_wr_data == epoch_reg))
        else $error("map write with stale epoch");

    // the cleared mark is never a live epoch
    a_epoch_live: assert property (@(posedge clk) disable iff (!rst_n)
        !clearing_reg |-> (epoch_reg != EPOCH_NONE))
        else $error("live epoch equals cleared mark");

endmodule

@@ hw/rtl/sparse_ternary_challenge_sampler.sv @@
`timescale 1ns / 1ps
// ============================================================================
// sparse_ternary_challenge_sampler
// Places signed unit coefficients at fresh positions drawn from XOF words.
// ============================================================================
// Takes one beat per cycle sustained while no clearing pass runs and the
// output is not stalled: each word needs one read-and-set of the occupancy
// map, a single-port-write RAM with registered read, and the map stage
// handles one word every cycle with forwarding between neighbours. A taken
// word is written into a queue entry, its map read is issued from there, and
// the output register then loads its result. The map keeps an epoch mark per
// position so a begin clears it at once; after reset, and again at every 63rd
// begin, a clearing pass over all NUM_COEFFS (512) positions runs while no beat is
// taken. The weight register may be written at any time the block is idle and
// is accepted in the cycle it is offered.
module sparse_ternary_challenge_sampler
    import stcs_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [WEIGHT_W-1:0] cfg_data,       // weight
    input  logic                s_axis_tvalid,
    output logic                s_axis_tready,
    input  logic [WORD_W-1:0]   s_axis_tdata,   // [15:0] word
    input  logic                s_axis_tuser,   // [0] op
    output logic                m_axis_tvalid,
    input  logic                m_axis_tready,
    output logic [15:0]         m_axis_tdata,   // [8:0] position, [9] positive
    output logic                m_axis_tlast    // last
);

    logic [WEIGHT_W-1:0] weight_reg;
    queue_head_t         head;
    logic                pop;
    logic                busy;

    // weight register
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            weight_reg <= WEIGHT_W'(19);
        end
        else if (cfg_valid)
        begin
            weight_reg <= cfg_data;
        end
    end

    // accept and classify
    stcs_front u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .busy          (busy),
        .head          (head),
        .pop           (pop)
    );

    // map update and results
    stcs_back u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .weight        (weight_reg),
        .head          (head),
        .pop           (pop),
        .busy          (busy),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

endmodule

@@ dv/stcs_checker.sv @@
`timescale 1ns / 1ps
// ============================================================================
// stcs_checker
// Watches the weight, word and coefficient channels of the challenge sampler,
// keeps its own occupancy map and count, predicts every placed coefficient and
// compares each result beat, field by field, with the oldest prediction.
// ============================================================================
module stcs_checker
    import stcs_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_valid,
    input  logic                cfg_ready,
    input  logic [WEIGHT_W-1:0] cfg_data,
    input  logic                s_axis_tvalid,
    input  logic                s_axis_tready,
    input  logic [WORD_W-1:0]   s_axis_tdata,   // [15:0] word
    input  logic                s_axis_tuser,   // [0] op
    input  logic                m_axis_tvalid,
    input  logic                m_axis_tready,
    input  logic [15:0]         m_axis_tdata,   // [8:0] position, [9] positive
    input  logic                m_axis_tlast,   // last
    output int                  fail_count,
    output int                  pending
);

    localparam logic [WEIGHT_W-1:0] WEIGHT_AT_RESET = WEIGHT_W'(19);

    // one predicted coefficient
    typedef struct packed {
        logic                  last;
        logic                  positive;
        logic [POSITION_W-1:0] position;
    } coeff_t;

    coeff_t              expected_coeffs[$];
    logic                occupied [NUM_COEFFS];
    logic [WEIGHT_W-1:0] weight_q;
    logic [WEIGHT_W-1:0] placed_count;
    int                  fails;

    // predict the effect of one accepted input beat
    task automatic sample_coeff(input logic op, input logic [WORD_W-1:0] word);
        logic [POS_W-1:0] slot;
        coeff_t           coeff;
        if (op == OP_BEGIN)
        begin
            for (int k = 0; k < NUM_COEFFS; k++)
                occupied[POS_W'(k)] = 1'b0;
            placed_count = '0;
        end
        else if (placed_count < weight_q)
        begin
            slot = POS_W'((word >> 1) & WORD_W'(NUM_COEFFS - 1));
            if (!occupied[slot])
            begin
                occupied[slot]  = 1'b1;
                placed_count    = placed_count + 1'b1;
                coeff.position  = POSITION_W'(slot);
                coeff.positive  = word[0];
                coeff.last      = (placed_count == weight_q);
                expected_coeffs.push_back(coeff);
            end
        end
    endtask

    // compare one result beat with the oldest prediction
    task automatic check_coeff();
        coeff_t want;
        if (expected_coeffs.size() == 0)
        begin
            $display("%0t: unexpected coefficient position %0d positive %0b last %0b",
                     $time, m_axis_tdata[POSITION_W-1:0], m_axis_tdata[POSITION_W],
                     m_axis_tlast);
            fails++;
        end
        else
        begin
            want = expected_coeffs.pop_front();
            if (m_axis_tdata[POSITION_W-1:0] !== want.position)
            begin
                $display("%0t: position expected %0d, actual %0d",
                         $time, want.position, m_axis_tdata[POSITION_W-1:0]);
                fails++;
            end
            if (m_axis_tdata[POSITION_W] !== want.positive)
            begin
                $display("%0t: positive expected %0b, actual %0b",
                         $time, want.positive, m_axis_tdata[POSITION_W]);
                fails++;
            end
            if (m_axis_tlast !== want.last)
            begin
                $display("%0t: last expected %0b, actual %0b",
                         $time, want.last, m_axis_tlast);
                fails++;
            end
        end
    endtask

    // results first, then weight writes, then new words
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < NUM_COEFFS; k++)
                occupied[POS_W'(k)] = 1'b0;
            placed_count = '0;
            weight_q     = WEIGHT_AT_RESET;
            fails        = 0;
            expected_coeffs.delete();
            fail_count <= 0;
            pending    <= 0;
        end
        else
        begin
            if (m_axis_tvalid && m_axis_tready)
                check_coeff();
            if (cfg_valid && cfg_ready)
                weight_q = cfg_data;
            if (s_axis_tvalid && s_axis_tready)
                sample_coeff(s_axis_tuser, s_axis_tdata);
            fail_count <= fails;
            pending    <= expected_coeffs.size();
        end
    end

endmodule

@@ dv/tb_top.sv @@
`timescale 1ns / 1ps
// ============================================================================
// tb_top
// Stimulus and verdict for the sparse ternary challenge sampler: directed
// corner cases, random challenges over many weights, a long output stall, a
// weight beyond the map, and a gap-free tail; checking is done by stcs_checker.
// ============================================================================
module tb_top;
    import stcs_pkg::*;

    localparam int RANDOM_WORDS   = 350;
    localparam int STALL_WORDS    = 40;
    localparam int LONG_HOLD      = 150;
    localparam int DRAIN_SETTLE   = 8;
    localparam int END_SETTLE     = 20;
    localparam int WATCHDOG_LIMIT = 4000;

    logic                clk           = 1'b0;
    logic                rst_n         = 1'b0;
    logic                cfg_valid     = 1'b0;
    logic                cfg_ready;
    logic [WEIGHT_W-1:0] cfg_data      = '0;
    logic                s_axis_tvalid = 1'b0;
    logic                s_axis_tready;
    logic [WORD_W-1:0]   s_axis_tdata  = '0;
    logic                s_axis_tuser  = OP_BEGIN;
    logic                m_axis_tvalid;
    logic                m_axis_tready = 1'b0;
    logic [15:0]         m_axis_tdata;
    logic                m_axis_tlast;

    int fail_count;
    int pending;
    int idle_cycles = 0;
    int words_sent  = 0;
    bit tx_gaps     = 1'b1;
    bit rx_gaps     = 1'b1;
    bit rx_hold_req = 1'b0;

    // clock
    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    sparse_ternary_challenge_sampler u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_data      (cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    stcs_checker u_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_data      (cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .fail_count    (fail_count),
        .pending       (pending)
    );

    // watchdog on cycles without any beat
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
                (cfg_valid && cfg_ready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_LIMIT)
            begin
                $display("CHECK FAILED");
                $finish;
            end
        end
    end

    // coefficient receiver: random stalls, one long hold on request
    initial
    begin
        forever
        begin
            if (rx_hold_req)
            begin
                m_axis_tready <= 1'b0;
                repeat (LONG_HOLD) @(posedge clk);
                rx_hold_req = 1'b0;
            end
            else if (rx_gaps && $urandom_range(0, 3) == 0)
            begin
                m_axis_tready <= 1'b0;
                repeat ($urandom_range(1, 10)) @(posedge clk);
            end
            else
            begin
                m_axis_tready <= 1'b1;
                @(posedge clk);
            end
        end
    end

    // offer one input beat, with an optional gap before it
    task automatic send_beat(input logic op, input logic [WORD_W-1:0] word);
        if (tx_gaps && $urandom_range(0, 5) == 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 10)) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= op;
        s_axis_tdata  <= word;
        do
            @(posedge clk);
        while (!s_axis_tready);
        if (op == OP_WORD)
            words_sent++;
    endtask

    // stop sending and wait for every predicted coefficient
    task automatic drain();
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (DRAIN_SETTLE) @(posedge clk);
    endtask

    task automatic write_weight(input logic [WEIGHT_W-1:0] w);
        cfg_valid <= 1'b1;
        cfg_data  <= w;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
    endtask

    // one challenge: a few begins, then about enough random words to finish
    task automatic run_challenge(input int w);
        int n;
        repeat ($urandom_range(1, 3)) send_beat(OP_BEGIN, 16'($urandom_range(0, 65535)));
        n = w + $urandom_range(0, w / 4 + 3);
        // cut short now and then
        if ($urandom_range(0, 7) == 0)
            n = $urandom_range(0, w);
        repeat (n) send_beat(OP_WORD, 16'($urandom_range(0, 65535)));
    endtask

    // main sequence
    initial
    begin
        int w;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // words before any begin, reset weight, masking and repeats
        send_beat(OP_WORD, 16'hFFFF);
        send_beat(OP_WORD, 16'h0000);
        send_beat(OP_WORD, 16'h0001);
        send_beat(OP_BEGIN, 16'hFFFF);
        send_beat(OP_WORD, 16'hFFFF);
        send_beat(OP_WORD, 16'h8002);
        send_beat(OP_WORD, 16'h0402);
        send_beat(OP_WORD, 16'hAAAA);
        send_beat(OP_WORD, 16'h5555);
        drain();

        // weight of one: first word completes, next is ignored
        write_weight(WEIGHT_W'(1));
        send_beat(OP_BEGIN, 16'h0000);
        send_beat(OP_WORD, 16'h7FFE);
        send_beat(OP_WORD, 16'h0003);
        drain();

        // weight zero: complete at once
        write_weight(WEIGHT_W'(0));
        send_beat(OP_BEGIN, 16'h0000);
        send_beat(OP_WORD, 16'h1234);
        send_beat(OP_WORD, 16'hFEDC);
        drain();

        // finish at three, lower below the count, then raise and continue
        write_weight(WEIGHT_W'(3));
        send_beat(OP_BEGIN, 16'h0000);
        send_beat(OP_WORD, 16'h0010);
        send_beat(OP_WORD, 16'h0021);
        send_beat(OP_WORD, 16'h0031);
        drain();
        write_weight(WEIGHT_W'(2));
        send_beat(OP_WORD, 16'h0041);
        drain();
        write_weight(WEIGHT_W'(5));
        send_beat(OP_WORD, 16'h0051);
        send_beat(OP_WORD, 16'h0061);
        drain();

        // random challenges over many weights
        words_sent = 0;
        while (words_sent < RANDOM_WORDS)
        begin
            case ($urandom_range(0, 9))
                0:       w = 1;
                1:       w = $urandom_range(31, 60);
                default: w = $urandom_range(2, 30);
            endcase
            tx_gaps = ($urandom_range(0, 3) != 0);
            rx_gaps = ($urandom_range(0, 3) != 0);
            write_weight(WEIGHT_W'(w));
            repeat ($urandom_range(1, 2)) run_challenge(w);
            drain();
        end

        // long output stall while words keep coming
        tx_gaps = 1'b0;
        rx_gaps = 1'b1;
        write_weight(WEIGHT_W'(100));
        rx_hold_req = 1'b1;
        send_beat(OP_BEGIN, 16'($urandom_range(0, 65535)));
        repeat (STALL_WORDS) send_beat(OP_WORD, 16'($urandom_range(0, 65535)));
        drain();

        // weight beyond the map: last is never raised
        tx_gaps = 1'b1;
        write_weight({WEIGHT_W{1'b1}});
        send_beat(OP_BEGIN, 16'($urandom_range(0, 65535)));
        repeat (10) send_beat(OP_WORD, 16'($urandom_range(0, 65535)));
        drain();

        // tail without any idling
        tx_gaps = 1'b0;
        rx_gaps = 1'b0;
        w = $urandom_range(2, 30);
        write_weight(WEIGHT_W'(w));
        repeat (3) run_challenge(w);
        drain();

        repeat (END_SETTLE) @(posedge clk);
        if (fail_count == 0 && pending == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
